>>> rtl/core/tsrwb_pkg.sv
// Shared types, constants and the tanh table for the tilt-shift row weight blend.
// Used by tsrwb_div and tilt_shift_row_weight_blend; depends on nothing else.
package tsrwb_pkg;

  localparam int ROW_BITS       = 12;
  localparam int TANH_FRAC_BITS = 8;
  localparam int PIX_BITS       = 8;
  localparam int WIDTH_BITS     = 7;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;

  // |r - c +/- h| and the signed sum itself
  localparam int MAG_BITS = ROW_BITS + 1;
  localparam int SUM_BITS = ROW_BITS + 2;

  // tanh argument, clamped at 8.0
  localparam int ARG_BITS    = TANH_FRAC_BITS + 4;
  localparam int ARG_LIMIT   = 8 << TANH_FRAC_BITS;
  localparam int INTERP_BITS = TANH_FRAC_BITS - 2;
  localparam int IDX_BITS    = ARG_BITS - INTERP_BITS;
  localparam int TANH_BITS   = 17;
  localparam int T_BITS      = TANH_BITS + 1;
  localparam int DIFF_BITS   = TANH_BITS + 1;
  localparam int WPROD_BITS  = DIFF_BITS + PIX_BITS;
  localparam int PROD_BITS   = 2 * PIX_BITS;

  // long division, a fixed number of restoring steps per pipeline stage
  localparam int DIV_STEPS  = 7;
  localparam int DIV_STAGES = (MAG_BITS + TANH_FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_BITS   = DIV_STAGES * DIV_STEPS;

  // stage 0 args, divider, lookup, interpolation, weight, products
  localparam int PIPE_DEPTH = DIV_STAGES + 5;
  localparam int ST_LOOKUP  = DIV_STAGES + 1;
  localparam int ST_INTERP  = DIV_STAGES + 2;
  localparam int ST_WEIGHT  = DIV_STAGES + 3;
  localparam int ST_PROD    = DIV_STAGES + 4;

  localparam logic [ARG_BITS-1:0]   ARG_MAX    = ARG_BITS'(ARG_LIMIT);
  localparam logic [WIDTH_BITS-1:0] WIDTH_ONE  = WIDTH_BITS'(1);
  localparam logic [WIDTH_BITS-1:0] WIDTH_RST  = WIDTH_BITS'(31);
  localparam logic [PIX_BITS-1:0]   PIX_MAX    = PIX_BITS'(255);
  localparam logic [PROD_BITS-1:0]  ROUND_BIAS = PROD_BITS'(127);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BAND_CENTER_ROW  = 2'd0,
    REG_BAND_HALF_HEIGHT = 2'd1,
    REG_TRANSITION_WIDTH = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_index;
    logic [PIX_BITS-1:0] sharp_blue;
    logic [PIX_BITS-1:0] sharp_green;
    logic [PIX_BITS-1:0] sharp_red;
    logic [PIX_BITS-1:0] blur_blue;
    logic [PIX_BITS-1:0] blur_green;
    logic [PIX_BITS-1:0] blur_red;
  } tsrwb_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_blue;
    logic [PIX_BITS-1:0] out_green;
    logic [PIX_BITS-1:0] out_red;
    logic [PIX_BITS-1:0] sharp_weight;
  } tsrwb_out_t;

  // tanh(k/4) in Q16; everything from k = 25 up is 1.0
  function automatic logic [TANH_BITS-1:0] tanh_q16(input logic [IDX_BITS-1:0] k);
    logic [TANH_BITS-1:0] v;
    case (k)
      0:       v = TANH_BITS'(0);
      1:       v = TANH_BITS'(16051);
      2:       v = TANH_BITS'(30285);
      3:       v = TANH_BITS'(41625);
      4:       v = TANH_BITS'(49912);
      5:       v = TANH_BITS'(55593);
      6:       v = TANH_BITS'(59320);
      7:       v = TANH_BITS'(61694);
      8:       v = TANH_BITS'(63179);
      9:       v = TANH_BITS'(64096);
      10:      v = TANH_BITS'(64659);
      11:      v = TANH_BITS'(65003);
      12:      v = TANH_BITS'(65212);
      13:      v = TANH_BITS'(65339);
      14:      v = TANH_BITS'(65417);
      15:      v = TANH_BITS'(65464);
      16:      v = TANH_BITS'(65492);
      17:      v = TANH_BITS'(65509);
      18:      v = TANH_BITS'(65520);
      19:      v = TANH_BITS'(65526);
      20:      v = TANH_BITS'(65530);
      21:      v = TANH_BITS'(65532);
      22:      v = TANH_BITS'(65534);
      23:      v = TANH_BITS'(65535);
      24:      v = TANH_BITS'(65535);
      default: v = TANH_BITS'(65536);
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/tsrwb_div.sv
// Pipelined restoring divider: (mag << TANH_FRAC_BITS) / dv, clamped to 8.0.
// Depends on tsrwb_pkg; DIV_STAGES register stages, advanced by en.
module tsrwb_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic [tsrwb_pkg::MAG_BITS-1:0]      mag,
  input  logic [tsrwb_pkg::WIDTH_BITS-1:0]    dv,
  output logic [tsrwb_pkg::ARG_BITS-1:0]      arg
);

  typedef struct packed {
    logic [tsrwb_pkg::DIV_BITS-1:0]   num;
    logic [tsrwb_pkg::WIDTH_BITS-1:0] rem;
    logic [tsrwb_pkg::ARG_BITS-1:0]   quo;
    logic                             ovf;
  } div_state_t;

  div_state_t st    [tsrwb_pkg::DIV_STAGES];
  div_state_t st_in [tsrwb_pkg::DIV_STAGES];

  function automatic logic [tsrwb_pkg::DIV_BITS-1:0] dividend(
    input logic [tsrwb_pkg::MAG_BITS-1:0] m
  );
    logic [tsrwb_pkg::DIV_BITS-1:0] t;
    t = '0;
    t[tsrwb_pkg::MAG_BITS+tsrwb_pkg::TANH_FRAC_BITS-1:tsrwb_pkg::TANH_FRAC_BITS] = m;
    return t;
  endfunction

  function automatic div_state_t div_steps(
    input div_state_t                        s,
    input logic [tsrwb_pkg::WIDTH_BITS-1:0]  d
  );
    div_state_t                        t;
    logic [tsrwb_pkg::WIDTH_BITS:0]    trial;
    t = s;
    for (int k = 0; k < tsrwb_pkg::DIV_STEPS; k++) begin
      trial = {t.rem, t.num[tsrwb_pkg::DIV_BITS-1]};
      t.num = t.num << 1;
      // quotient bits beyond the clamp range only matter as a sticky flag
      t.ovf = t.ovf | t.quo[tsrwb_pkg::ARG_BITS-1];
      if (trial >= {1'b0, d}) begin
        trial = trial - {1'b0, d};
        t.quo = {t.quo[tsrwb_pkg::ARG_BITS-2:0], 1'b1};
      end else begin
        t.quo = {t.quo[tsrwb_pkg::ARG_BITS-2:0], 1'b0};
      end
      t.rem = trial[tsrwb_pkg::WIDTH_BITS-1:0];
    end
    return t;
  endfunction

  always_comb begin
    st_in[0].num = dividend(mag);
    st_in[0].rem = '0;
    st_in[0].quo = '0;
    st_in[0].ovf = 1'b0;
    for (int i = 1; i < tsrwb_pkg::DIV_STAGES; i++) begin
      st_in[i] = st[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tsrwb_pkg::DIV_STAGES; i++) begin
        st[i] <= div_steps(st_in[i], dv);
      end
    end
  end

  assign arg = (st[tsrwb_pkg::DIV_STAGES-1].ovf ||
                st[tsrwb_pkg::DIV_STAGES-1].quo > tsrwb_pkg::ARG_MAX)
               ? tsrwb_pkg::ARG_MAX : st[tsrwb_pkg::DIV_STAGES-1].quo;

endmodule

>>> rtl/core/tilt_shift_row_weight_blend.sv
// Tilt-shift row weight blend, top level: tanh band mask and per-channel blend.
// Depends on tsrwb_pkg and tsrwb_div.
//
// Takes one pixel per clock while in_ready is high and returns one blended
// pixel per pixel, in order. A pixel passes through PIPE_DEPTH = 8 register
// stages (argument, three stages of seven long-division steps each for the
// two tanh arguments, table lookup, interpolation, weight, channel products)
// and then the output register; the first stage loads at the input
// transaction. A skid register behind the pipeline catches the pixel that
// arrives while the output is stalled; in_ready is low while it is occupied.
// Configuration writes take effect at once and are meant for idle periods;
// a transition width of 0 acts as 1.
module tilt_shift_row_weight_blend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tsrwb_pkg::tsrwb_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tsrwb_pkg::tsrwb_out_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [tsrwb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tsrwb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // configuration
  logic [tsrwb_pkg::ROW_BITS-1:0]   band_center_row;
  logic [tsrwb_pkg::ROW_BITS-1:0]   band_half_height;
  logic [tsrwb_pkg::WIDTH_BITS-1:0] transition_width;
  logic [tsrwb_pkg::WIDTH_BITS-1:0] dv;

  // pipeline control
  logic                        en;
  logic [tsrwb_pkg::PIPE_DEPTH-1:0] v;
  logic                        push;
  logic                        take;

  // stage 0: argument numerators
  logic signed [tsrwb_pkg::SUM_BITS-1:0] n_a;
  logic signed [tsrwb_pkg::SUM_BITS-1:0] n_b;
  logic signed [tsrwb_pkg::SUM_BITS-1:0] base;
  logic [tsrwb_pkg::MAG_BITS-1:0]        mag_a;
  logic [tsrwb_pkg::MAG_BITS-1:0]        mag_b;
  logic                                  neg_a [tsrwb_pkg::DIV_STAGES+1];
  logic                                  neg_b [tsrwb_pkg::DIV_STAGES+1];
  tsrwb_pkg::tsrwb_in_t                  pix   [tsrwb_pkg::ST_WEIGHT+1];

  // divider results
  logic [tsrwb_pkg::ARG_BITS-1:0] arg_a;
  logic [tsrwb_pkg::ARG_BITS-1:0] arg_b;

  // lookup stage
  logic [tsrwb_pkg::TANH_BITS-1:0]   lo_a;
  logic [tsrwb_pkg::TANH_BITS-1:0]   lo_b;
  logic [tsrwb_pkg::TANH_BITS-1:0]   step_a;
  logic [tsrwb_pkg::TANH_BITS-1:0]   step_b;
  logic [tsrwb_pkg::INTERP_BITS-1:0] frac_a;
  logic [tsrwb_pkg::INTERP_BITS-1:0] frac_b;
  logic                              sgn_a;
  logic                              sgn_b;
  logic [tsrwb_pkg::TANH_BITS-1:0]   lo_a_next;
  logic [tsrwb_pkg::TANH_BITS-1:0]   lo_b_next;
  logic [tsrwb_pkg::TANH_BITS-1:0]   step_a_next;
  logic [tsrwb_pkg::TANH_BITS-1:0]   step_b_next;

  // interpolation stage
  logic signed [tsrwb_pkg::T_BITS-1:0] t_a;
  logic signed [tsrwb_pkg::T_BITS-1:0] t_b;
  logic signed [tsrwb_pkg::T_BITS-1:0] t_a_next;
  logic signed [tsrwb_pkg::T_BITS-1:0] t_b_next;

  // weight stage
  logic [tsrwb_pkg::PIX_BITS-1:0]      w;
  logic [tsrwb_pkg::PIX_BITS-1:0]      w_next;
  logic signed [tsrwb_pkg::T_BITS:0]   dd;
  logic [tsrwb_pkg::DIFF_BITS-1:0]     dpos;
  logic [tsrwb_pkg::WPROD_BITS-1:0]    wprod;
  logic [tsrwb_pkg::PIX_BITS:0]        wq;

  // product stage
  logic [tsrwb_pkg::PIX_BITS-1:0]  w_p;
  logic [tsrwb_pkg::PIX_BITS-1:0]  inv_w;
  logic [tsrwb_pkg::PROD_BITS-1:0] ps_b, ps_g, ps_r;
  logic [tsrwb_pkg::PROD_BITS-1:0] pb_b, pb_g, pb_r;

  // output side
  tsrwb_pkg::tsrwb_out_t fin;
  tsrwb_pkg::tsrwb_out_t skid_data;
  logic                  skid_valid;

  function automatic logic [tsrwb_pkg::PROD_BITS-1:0] mul8(
    input logic [tsrwb_pkg::PIX_BITS-1:0] a,
    input logic [tsrwb_pkg::PIX_BITS-1:0] b
  );
    logic [tsrwb_pkg::PROD_BITS-1:0] p;
    p = {{tsrwb_pkg::PIX_BITS{1'b0}}, a} * {{tsrwb_pkg::PIX_BITS{1'b0}}, b};
    return p + tsrwb_pkg::ROUND_BIAS;
  endfunction

  // x / 255 for x < 65280, exact
  function automatic logic [tsrwb_pkg::PIX_BITS-1:0] div255(
    input logic [tsrwb_pkg::PROD_BITS-1:0] x
  );
    logic [tsrwb_pkg::PROD_BITS:0] s;
    s = {1'b0, x}
      + {{(tsrwb_pkg::PROD_BITS+1-tsrwb_pkg::PIX_BITS){1'b0}},
         x[tsrwb_pkg::PROD_BITS-1:tsrwb_pkg::PIX_BITS]}
      + {{tsrwb_pkg::PROD_BITS{1'b0}}, 1'b1};
    return s[tsrwb_pkg::PROD_BITS-1:tsrwb_pkg::PIX_BITS];
  endfunction

  function automatic logic [tsrwb_pkg::PIX_BITS-1:0] blend(
    input logic [tsrwb_pkg::PROD_BITS-1:0] ps,
    input logic [tsrwb_pkg::PROD_BITS-1:0] pb
  );
    logic [tsrwb_pkg::PIX_BITS:0] s;
    s = {1'b0, div255(ps)} + {1'b0, div255(pb)};
    return s[tsrwb_pkg::PIX_BITS] ? tsrwb_pkg::PIX_MAX : s[tsrwb_pkg::PIX_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      band_center_row  <= '0;
      band_half_height <= '0;
      transition_width <= tsrwb_pkg::WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsrwb_pkg::REG_BAND_CENTER_ROW:
          band_center_row <= cfg_data[tsrwb_pkg::ROW_BITS-1:0];
        tsrwb_pkg::REG_BAND_HALF_HEIGHT:
          band_half_height <= cfg_data[tsrwb_pkg::ROW_BITS-1:0];
        tsrwb_pkg::REG_TRANSITION_WIDTH:
          transition_width <= cfg_data[tsrwb_pkg::WIDTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign dv = (transition_width == '0) ? tsrwb_pkg::WIDTH_ONE : transition_width;

  // ---------------------------------------------------------------- control
  // whole pipeline advances unless the skid register is holding a result
  assign en       = !skid_valid;
  assign in_ready = en;
  assign push     = en && v[tsrwb_pkg::PIPE_DEPTH-1];
  assign take     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[tsrwb_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- stage 0
  always_comb begin
    base = $signed({2'b00, in_data.row_index}) - $signed({2'b00, band_center_row});
    n_a  = base + $signed({2'b00, band_half_height});
    n_b  = base - $signed({2'b00, band_half_height});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a[0] <= n_a[tsrwb_pkg::SUM_BITS-1];
      neg_b[0] <= n_b[tsrwb_pkg::SUM_BITS-1];
      mag_a    <= n_a[tsrwb_pkg::SUM_BITS-1] ? tsrwb_pkg::MAG_BITS'(-n_a)
                                             : tsrwb_pkg::MAG_BITS'(n_a);
      mag_b    <= n_b[tsrwb_pkg::SUM_BITS-1] ? tsrwb_pkg::MAG_BITS'(-n_b)
                                             : tsrwb_pkg::MAG_BITS'(n_b);
      pix[0]   <= in_data;
      for (int i = 1; i <= tsrwb_pkg::DIV_STAGES; i++) begin
        neg_a[i] <= neg_a[i-1];
        neg_b[i] <= neg_b[i-1];
      end
      for (int i = 1; i <= tsrwb_pkg::ST_WEIGHT; i++) begin
        pix[i] <= pix[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- divide
  tsrwb_div u_div_a (
    .clk (clk),
    .en  (en),
    .mag (mag_a),
    .dv  (dv),
    .arg (arg_a)
  );

  tsrwb_div u_div_b (
    .clk (clk),
    .en  (en),
    .mag (mag_b),
    .dv  (dv),
    .arg (arg_b)
  );

  // ---------------------------------------------------------------- lookup
  always_comb begin
    lo_a_next   = tsrwb_pkg::tanh_q16(arg_a[tsrwb_pkg::ARG_BITS-1:tsrwb_pkg::INTERP_BITS]);
    lo_b_next   = tsrwb_pkg::tanh_q16(arg_b[tsrwb_pkg::ARG_BITS-1:tsrwb_pkg::INTERP_BITS]);
    step_a_next = tsrwb_pkg::tanh_q16(arg_a[tsrwb_pkg::ARG_BITS-1:tsrwb_pkg::INTERP_BITS]
                                      + 1'b1) - lo_a_next;
    step_b_next = tsrwb_pkg::tanh_q16(arg_b[tsrwb_pkg::ARG_BITS-1:tsrwb_pkg::INTERP_BITS]
                                      + 1'b1) - lo_b_next;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_a   <= lo_a_next;
      lo_b   <= lo_b_next;
      step_a <= step_a_next;
      step_b <= step_b_next;
      frac_a <= arg_a[tsrwb_pkg::INTERP_BITS-1:0];
      frac_b <= arg_b[tsrwb_pkg::INTERP_BITS-1:0];
      sgn_a  <= neg_a[tsrwb_pkg::DIV_STAGES];
      sgn_b  <= neg_b[tsrwb_pkg::DIV_STAGES];
    end
  end

  // ---------------------------------------------------------------- interpolate
  function automatic logic signed [tsrwb_pkg::T_BITS-1:0] interp(
    input logic [tsrwb_pkg::TANH_BITS-1:0]   lo,
    input logic [tsrwb_pkg::TANH_BITS-1:0]   st,
    input logic [tsrwb_pkg::INTERP_BITS-1:0] f,
    input logic                              neg
  );
    logic [tsrwb_pkg::TANH_BITS+tsrwb_pkg::INTERP_BITS-1:0] p;
    logic [tsrwb_pkg::TANH_BITS-1:0]                        val;
    logic signed [tsrwb_pkg::T_BITS-1:0]                    sv;
    p   = {{tsrwb_pkg::INTERP_BITS{1'b0}}, st} * {{tsrwb_pkg::TANH_BITS{1'b0}}, f};
    val = lo + p[tsrwb_pkg::TANH_BITS+tsrwb_pkg::INTERP_BITS-1:tsrwb_pkg::INTERP_BITS];
    sv  = $signed({1'b0, val});
    return neg ? -sv : sv;
  endfunction

  assign t_a_next = interp(lo_a, step_a, frac_a, sgn_a);
  assign t_b_next = interp(lo_b, step_b, frac_b, sgn_b);

  always_ff @(posedge clk) begin
    if (en) begin
      t_a <= t_a_next;
      t_b <= t_b_next;
    end
  end

  // ---------------------------------------------------------------- weight
  always_comb begin
    dd    = {t_a[tsrwb_pkg::T_BITS-1], t_a} - {t_b[tsrwb_pkg::T_BITS-1], t_b};
    dpos  = dd[tsrwb_pkg::T_BITS] ? '0 : dd[tsrwb_pkg::DIFF_BITS-1:0];
    wprod = {{tsrwb_pkg::PIX_BITS{1'b0}}, dpos}
          * {{tsrwb_pkg::DIFF_BITS{1'b0}}, tsrwb_pkg::PIX_MAX};
    wq    = wprod[tsrwb_pkg::WPROD_BITS-1:tsrwb_pkg::TANH_BITS];
    w_next = wq[tsrwb_pkg::PIX_BITS] ? tsrwb_pkg::PIX_MAX : wq[tsrwb_pkg::PIX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_next;
    end
  end

  // ---------------------------------------------------------------- products
  assign inv_w = tsrwb_pkg::PIX_MAX - w;

  always_ff @(posedge clk) begin
    if (en) begin
      w_p  <= w;
      ps_b <= mul8(pix[tsrwb_pkg::ST_WEIGHT].sharp_blue,  w);
      ps_g <= mul8(pix[tsrwb_pkg::ST_WEIGHT].sharp_green, w);
      ps_r <= mul8(pix[tsrwb_pkg::ST_WEIGHT].sharp_red,   w);
      pb_b <= mul8(pix[tsrwb_pkg::ST_WEIGHT].blur_blue,   inv_w);
      pb_g <= mul8(pix[tsrwb_pkg::ST_WEIGHT].blur_green,  inv_w);
      pb_r <= mul8(pix[tsrwb_pkg::ST_WEIGHT].blur_red,    inv_w);
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    fin.out_blue     = blend(ps_b, pb_b);
    fin.out_green    = blend(ps_g, pb_g);
    fin.out_red      = blend(ps_r, pb_r);
    fin.sharp_weight = w_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= skid_valid ? skid_data : fin;
    end else if (push) begin
      skid_data <= fin;
    end
  end

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a transaction while output is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid register filled without an output stall");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline valid bits moved while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted transaction missing from first stage");

endmodule

>>> bench/testbench.sv
// Self-checking bench for tilt_shift_row_weight_blend: drives pixels with random handshake gaps,
// predicts every blended pixel in-bench and checks results in order.
// Depends on tsrwb_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BITS       = tsrwb_pkg::ROW_BITS;
  localparam int WIDTH_BITS     = tsrwb_pkg::WIDTH_BITS;
  localparam int PIX_BITS       = tsrwb_pkg::PIX_BITS;
  localparam int CFG_INDEX_BITS = tsrwb_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS  = tsrwb_pkg::CFG_DATA_BITS;
  localparam int TANH_FRAC_BITS = tsrwb_pkg::TANH_FRAC_BITS;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int END_SETTLE     = 2 * tsrwb_pkg::PIPE_DEPTH + 4;
  localparam int LERP_SHIFT     = TANH_FRAC_BITS - 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 2'd3;

  // tanh(k/4), k = 0..32, Q16
  localparam int unsigned TANH_STEPS_Q16 [0:32] = '{
    0, 16051, 30285, 41625, 49912, 55593, 59320, 61694,
    63179, 64096, 64659, 65003, 65212, 65339, 65417, 65464,
    65492, 65509, 65520, 65526, 65530, 65532, 65534, 65535,
    65535, 65536, 65536, 65536, 65536, 65536, 65536, 65536,
    65536
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  tsrwb_pkg::tsrwb_in_t in_data;
  logic out_valid;
  logic out_ready;
  tsrwb_pkg::tsrwb_out_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // shadow copy of the band registers
  logic [ROW_BITS-1:0] cur_center;
  logic [ROW_BITS-1:0] cur_half;
  logic [WIDTH_BITS-1:0] cur_width;

  tsrwb_pkg::tsrwb_out_t pending_blends [$];
  tsrwb_pkg::tsrwb_out_t oldest_blend;
  int mismatch_count = 0;
  int cycle_count = 0;

  bit tx_idle_on;
  bit rx_idle_on = 1'b0;
  int rx_stall_left = 0;
  int rx_hold_left = 0;
  int rx_hold_trigger = 0;
  int rx_hold_seen = 0;

  tilt_shift_row_weight_blend u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic longint band_tanh(input int n, input int dv);
    longint mag, x, idx, frac, lo, hi, val;
    mag = (n < 0) ? -longint'(n) : longint'(n);
    x = (mag << TANH_FRAC_BITS) / dv;
    if (x > (longint'(8) << TANH_FRAC_BITS)) x = longint'(8) << TANH_FRAC_BITS;
    idx = x >> LERP_SHIFT;
    frac = x & ((longint'(1) << LERP_SHIFT) - 1);
    if (idx >= 32) begin
      val = TANH_STEPS_Q16[32];
    end else begin
      lo = TANH_STEPS_Q16[idx];
      hi = TANH_STEPS_Q16[idx + 1];
      val = lo + (((hi - lo) * frac) >> LERP_SHIFT);
    end
    return (n < 0) ? -val : val;
  endfunction

  function automatic logic [PIX_BITS-1:0] blend_chan(input logic [PIX_BITS-1:0] s,
                                                      input logic [PIX_BITS-1:0] b,
                                                      input int unsigned w);
    int unsigned sum;
    sum = (int'(s) * w + 127) / 255 + (int'(b) * (255 - w) + 127) / 255;
    if (sum > 255) sum = 255;
    return sum[PIX_BITS-1:0];
  endfunction

  function automatic tsrwb_pkg::tsrwb_out_t blend_pixel(input tsrwb_pkg::tsrwb_in_t px);
    tsrwb_pkg::tsrwb_out_t res;
    int dv, n_hi, n_lo;
    longint diff;
    int unsigned w;
    dv = (cur_width == 0) ? 1 : int'(cur_width);
    n_hi = int'(px.row_index) - int'(cur_center) + int'(cur_half);
    n_lo = int'(px.row_index) - int'(cur_center) - int'(cur_half);
    diff = band_tanh(n_hi, dv) - band_tanh(n_lo, dv);
    if (diff < 0) diff = 0;
    w = int'((diff * 255) >> 17);
    if (w > 255) w = 255;
    res.out_blue     = blend_chan(px.sharp_blue, px.blur_blue, w);
    res.out_green    = blend_chan(px.sharp_green, px.blur_green, w);
    res.out_red      = blend_chan(px.sharp_red, px.blur_red, w);
    res.sharp_weight = w[PIX_BITS-1:0];
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic tsrwb_pkg::tsrwb_in_t make_pixel(input logic [ROW_BITS-1:0] row,
                                                      input logic [7:0] sb, sg, sr,
                                                      bb, bg, br);
    tsrwb_pkg::tsrwb_in_t px;
    px.row_index   = row;
    px.sharp_blue  = sb;
    px.sharp_green = sg;
    px.sharp_red   = sr;
    px.blur_blue   = bb;
    px.blur_green  = bg;
    px.blur_red    = br;
    return px;
  endfunction

  function automatic logic [PIX_BITS-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly rows around the band edges, where the weight moves
  function automatic logic [ROW_BITS-1:0] pick_row();
    int dv, span, base;
    dv = (cur_width == 0) ? 1 : int'(cur_width);
    span = 3 * dv + 2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        base = $urandom_range(0, 1) ? int'(cur_center) + int'(cur_half)
                                    : int'(cur_center) - int'(cur_half);
        return ROW_BITS'(base + int'($urandom_range(0, 2 * span)) - span);
      end
      6, 7: begin
        return ROW_BITS'(int'(cur_center) + int'($urandom_range(0, 2 * cur_half))
                         - int'(cur_half));
      end
      default: return ROW_BITS'($urandom);
    endcase
  endfunction

  function automatic tsrwb_pkg::tsrwb_in_t random_pixel();
    return make_pixel(pick_row(), rand_chan(), rand_chan(), rand_chan(),
                      rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic send_pixel(input tsrwb_pkg::tsrwb_in_t px);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    pending_blends.push_back(blend_pixel(px));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      tsrwb_pkg::REG_BAND_CENTER_ROW:  cur_center = data[ROW_BITS-1:0];
      tsrwb_pkg::REG_BAND_HALF_HEIGHT: cur_half = data[ROW_BITS-1:0];
      tsrwb_pkg::REG_TRANSITION_WIDTH: cur_width = data[WIDTH_BITS-1:0];
      default: ;
    endcase
  endtask

  // only ever called with the pipeline empty
  task automatic program_band(input logic [ROW_BITS-1:0] center, half,
                              input logic [CFG_DATA_BITS-1:0] width_word,
                              input bit with_stray);
    wait_for_drain();
    put_reg(tsrwb_pkg::REG_BAND_CENTER_ROW, center);
    put_reg(tsrwb_pkg::REG_BAND_HALF_HEIGHT, half);
    put_reg(tsrwb_pkg::REG_TRANSITION_WIDTH, width_word);
    if (with_stray) put_reg(REG_NONE, CFG_DATA_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  // ---------------- receiver and checker ----------------

  always @(posedge clk) begin
    if (rx_hold_trigger != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_trigger;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      rx_stall_left <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_blends.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        oldest_blend = pending_blends.pop_front();
        check_field("out_blue", oldest_blend.out_blue, out_data.out_blue);
        check_field("out_green", oldest_blend.out_green, out_data.out_green);
        check_field("out_red", oldest_blend.out_red, out_data.out_red);
        check_field("sharp_weight", oldest_blend.sharp_weight, out_data.sharp_weight);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------

  // reset band has zero height, so every pixel should come out as the blur
  task automatic test_reset_state();
    send_pixel(make_pixel(12'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd4095, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(12'd31, 8'hAA, 8'h55, 8'h0F, 8'h55, 8'hAA, 8'hF0));
  endtask

  task automatic test_band_extremes();
    // hard edge: width 1
    program_band(12'd2048, 12'd100, 12'd1, 1'b0);
    send_pixel(make_pixel(12'd2048, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd1948, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127));
    send_pixel(make_pixel(12'd2148, 8'd200, 8'd100, 8'd50, 8'd10, 8'd20, 8'd30));
    send_pixel(make_pixel(12'd1947, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(12'd2149, 8'd1, 8'd254, 8'd127, 8'd128, 8'd1, 8'd254));
    send_pixel(make_pixel(12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd4095, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    // zero width behaves as width 1
    program_band(12'd2048, 12'd100, 12'd0, 1'b0);
    send_pixel(make_pixel(12'd1948, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd2048, 8'd77, 8'd88, 8'd99, 8'd11, 8'd22, 8'd33));
    // width and half height beyond their nominal range
    program_band(12'd1000, 12'd4095, 12'h07F, 1'b0);
    send_pixel(make_pixel(12'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd4095, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    // band at the last row, junk above the width bits, write to the unused index
    program_band(12'd4095, 12'd2048, 12'hF65, 1'b1);
    send_pixel(make_pixel(12'd4095, 8'd255, 8'd128, 8'd0, 8'd0, 8'd128, 8'd255));
    send_pixel(make_pixel(12'd2047, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    // zero height with a narrow transition
    program_band(12'd2000, 12'd0, 12'd5, 1'b0);
    send_pixel(make_pixel(12'd2000, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(12'd1999, 8'd100, 8'd150, 8'd200, 8'd250, 8'd50, 8'd0));
  endtask

  task automatic test_random_bands();
    logic [ROW_BITS-1:0] center, half;
    logic [WIDTH_BITS-1:0] width;
    rx_idle_on <= 1'b1;
    tx_idle_on = 1'b1;
    repeat (8) begin
      center = ROW_BITS'($urandom);
      case ($urandom_range(0, 5))
        0: half = 12'd0;
        1: half = 12'd2048;
        2: half = 12'd4095;
        3: half = ROW_BITS'($urandom_range(0, 2048));
        default: half = ROW_BITS'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 6))
        0: width = 7'd0;
        1: width = 7'd1;
        2: width = 7'd101;
        3: width = 7'd127;
        default: width = WIDTH_BITS'($urandom_range(1, 101));
      endcase
      program_band(center, half, {5'($urandom), width}, 1'($urandom_range(0, 1)));
      repeat (140) send_pixel(random_pixel());
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_stall();
    program_band(ROW_BITS'($urandom), ROW_BITS'($urandom_range(0, 400)),
                 CFG_DATA_BITS'($urandom_range(1, 101)), 1'b0);
    tx_idle_on = 1'b0;
    rx_hold_trigger <= rx_hold_trigger + 1;
    repeat (80) send_pixel(random_pixel());
  endtask

  task automatic test_full_rate();
    program_band(ROW_BITS'($urandom), ROW_BITS'($urandom_range(0, 600)),
                 CFG_DATA_BITS'($urandom_range(1, 101)), 1'b0);
    rx_idle_on <= 1'b0;
    tx_idle_on = 1'b0;
    repeat (300) send_pixel(random_pixel());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_center = '0;
    cur_half = '0;
    cur_width = tsrwb_pkg::WIDTH_RST;
    tx_idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    rx_idle_on <= 1'b1;

    test_reset_state();
    test_band_extremes();
    test_random_bands();
    test_output_stall();
    test_full_rate();

    wait_for_drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_blends.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
